// ===== sv/shbi_pkg.sv =====
// shbi_pkg: types, constants and control structs for the string hash bucket index block
// no dependencies; imported by shbi_ctrl, shbi_dp and string_hash_bucket_index
package shbi_pkg;

	localparam int HASH_W  = 64;
	localparam int PRIME_W = 17;
	localparam int BKT_W   = 16;
	localparam int CNT_W   = $clog2(HASH_W);
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_HASH  = CNT_W'(HASH_W - 1);
	localparam logic [CNT_W-1:0] CNT_PRIME = CNT_W'(PRIME_W - 1);

	localparam logic REG_BUCKET_COUNT  = 1'b0;
	localparam logic REG_PRIME_MODULUS = 1'b1;

	localparam logic [BKT_W-1:0]   BUCKET_COUNT_RST  = BKT_W'(1);
	localparam logic [PRIME_W-1:0] PRIME_MODULUS_RST = PRIME_W'(2);

	localparam logic DIV_BY_PRIME  = 1'b0;
	localparam logic DIV_BY_BUCKET = 1'b1;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       key_last;
	} key_req_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash_value;
		logic [BKT_W-1:0]  bucket_index;
	} res_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD_PRIME,
		ST_MOD_BUCKET,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic hash_upd;
		logic load_hash;
		logic load_rem;
		logic div_step;
		logic div_sel;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic prime_zero;
		logic out_blocked;
	} dp_sts_t;

endpackage

// ===== sv/shbi_ctrl.sv =====
// shbi_ctrl: sequencer for the hash update and the two serial modulo passes
// depends on shbi_pkg; drives the commands of shbi_dp
module shbi_ctrl
	import shbi_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    key_valid,
	input  logic    key_last,
	output logic    key_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// non-final bytes keep flowing while a modulo runs
	assign key_stall = key_last && (state_q != ST_IDLE);
	assign accept    = key_valid && !key_stall;

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		cmd           = '0;
		cmd.hash_upd  = accept;
		cmd.div_sel   = DIV_BY_PRIME;
		case (state_q)
			ST_IDLE: begin
				if (accept && key_last) begin
					cmd.load_hash = 1'b1;
					cnt_d         = CNT_HASH;
					state_d       = sts.prime_zero ? ST_MOD_BUCKET : ST_MOD_PRIME;
				end
			end
			ST_MOD_PRIME: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					cmd.div_step = 1'b0;
					cmd.load_rem = 1'b1;
					cnt_d        = CNT_PRIME;
					state_d      = ST_MOD_BUCKET;
				end
			end
			ST_MOD_BUCKET: begin
				cmd.div_sel  = DIV_BY_BUCKET;
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_blocked) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/shbi_dp.sv =====
// shbi_dp: running hash, shared shift-subtract remainder unit and result register
// depends on shbi_pkg; commanded by shbi_ctrl
module shbi_dp
	import shbi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  key_req_t           key,
	input  logic [BKT_W-1:0]   bucket_count,
	input  logic [PRIME_W-1:0] prime_modulus,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	output logic               res_valid,
	input  logic               res_stall,
	output res_req_t           res
);

	logic [HASH_W-1:0]  hash_q, hash_nxt, byte_ext;
	logic [HASH_W-1:0]  work_hash_q;
	logic [HASH_W-1:0]  dv_q;
	logic [PRIME_W-1:0] rem_q, rem_nxt, divisor;
	logic [PRIME_W:0]   trial, dsr, diff;
	logic               out_valid_q;
	res_req_t           out_q;

	assign byte_ext = {{(HASH_W - 8){key.key_byte[7]}}, key.key_byte};
	assign hash_nxt = byte_ext + (hash_q << 6) + (hash_q << 16) - hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (cmd.hash_upd) begin
			hash_q <= key.key_last ? '0 : hash_nxt;
		end
	end

	// one remainder bit per cycle, dividend msb first
	assign divisor = (cmd.div_sel == DIV_BY_BUCKET) ? {1'b0, bucket_count} : prime_modulus;
	assign trial   = {rem_q, dv_q[HASH_W-1]};
	assign dsr     = {1'b0, divisor};
	assign diff    = trial - dsr;
	assign rem_nxt = (trial >= dsr) ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_hash) begin
			work_hash_q <= hash_nxt;
			dv_q        <= hash_nxt;
			rem_q       <= '0;
		end else if (cmd.load_rem) begin
			// last step by the prime feeds the bucket pass directly
			dv_q  <= {rem_nxt, {(HASH_W - PRIME_W){1'b0}}};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dv_q  <= {dv_q[HASH_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.hash_value   <= work_hash_q;
			out_q.bucket_index <= (bucket_count == '0) ? '0 : rem_q[BKT_W-1:0];
		end
	end

	assign sts.prime_zero  = (prime_modulus == '0);
	assign sts.out_blocked = out_valid_q && res_stall;
	assign res_valid       = out_valid_q;
	assign res             = out_q;

endmodule

// ===== sv/string_hash_bucket_index.sv =====
// string_hash_bucket_index: top level, configuration registers and submodule wiring
// depends on shbi_pkg, shbi_ctrl and shbi_dp
//
// channel   direction  handshake              payload
// key       in         key_valid / key_stall  key_req_t (key_byte, key_last)
// res       out        res_valid / res_stall  res_req_t (hash_value, bucket_index)
// config    in         apb write, pready = 1  bucket_count @0x0, prime_modulus @0x4
//
// a non-final byte is accepted without a stall, also while a modulo pass is running
// a final byte starts the serial remainder unit: 64 steps by the prime, then 17 by
// the bucket count (64 by the bucket count alone when the prime is zero), and its
// result is loaded into the result register once that register is free; a further
// final byte is stalled until then
// the result register holds while res_stall is high and is refilled only once taken
// reset clears the hash, bucket_count to 1 and prime_modulus to 2
module string_hash_bucket_index
	import shbi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_valid,
	output logic               key_stall,
	input  key_req_t           key,
	output logic               res_valid,
	input  logic               res_stall,
	output res_req_t           res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [BKT_W-1:0]   bucket_count_q;
	logic [PRIME_W-1:0] prime_modulus_q;
	logic               wr_en;
	dp_cmd_t            cmd;
	dp_sts_t            sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q  <= BUCKET_COUNT_RST;
			prime_modulus_q <= PRIME_MODULUS_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_BUCKET_COUNT:  bucket_count_q  <= pwdata[BKT_W-1:0];
				REG_PRIME_MODULUS: prime_modulus_q <= pwdata[PRIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BUCKET_COUNT:  prdata = {{(PDATA_W - BKT_W){1'b0}}, bucket_count_q};
			REG_PRIME_MODULUS: prdata = {{(PDATA_W - PRIME_W){1'b0}}, prime_modulus_q};
			default:           prdata = '0;
		endcase
	end

	shbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_last  (key.key_last),
		.key_stall (key_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	shbi_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.key           (key),
		.bucket_count  (bucket_count_q),
		.prime_modulus (prime_modulus_q),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res           (res)
	);

endmodule
